@@ hdl/rhc_pkg.sv @@
// Shared types, constants and the divider step for the RGB to HSV converter.
package rhc_pkg;

    localparam int COMP_W        = 8;
    localparam int HUE_FRAC_BITS = 6;
    localparam int SAT_FRAC_BITS = 16;

    localparam int HUE_W = 15;
    localparam int SAT_W = 17;
    localparam int VAL_W = 8;

    // Quotient bits: hue is below 360 < 2^9 degrees, saturation is at most one.
    localparam int HUE_QW = HUE_FRAC_BITS + 9;
    localparam int SAT_QW = SAT_FRAC_BITS + 1;
    localparam int QW     = (HUE_QW > SAT_QW) ? HUE_QW : SAT_QW;

    // Divisor is twice a component, so one bit wider than a component.
    localparam int DIV_W = COMP_W + 1;
    localparam int NUM_W = QW + DIV_W;

    // 360 * 255 fits in 17 bits.
    localparam int SCALED_W = 17;
    localparam int OFF_W    = 9;

    localparam logic [OFF_W-1:0] OFFSET_RED      = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFFSET_RED_WRAP = OFF_W'(360);
    localparam logic [OFF_W-1:0] OFFSET_GREEN    = OFF_W'(120);
    localparam logic [OFF_W-1:0] OFFSET_BLUE     = OFF_W'(240);
    localparam logic [SCALED_W-1:0] SIXTY        = SCALED_W'(60);

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QW-1:0]    work;   // numerator bits shift out at the top, quotient in at the bottom
        logic [DIV_W-1:0] dvs;
    } div_lane_t;

    typedef struct packed {
        logic              valid;
        div_lane_t         hue;
        div_lane_t         sat;
        logic [VAL_W-1:0]  value;
    } stage_t;

    // One restoring division step: bring down one numerator bit, subtract if it fits.
    function automatic div_lane_t div_step(input div_lane_t cur);
        div_lane_t        nxt;
        logic [DIV_W:0]   trial;
        logic [DIV_W:0]   dvs_ext;
        trial   = {cur.rem, cur.work[QW-1]};
        dvs_ext = {1'b0, cur.dvs};
        nxt.dvs = cur.dvs;
        if (trial >= dvs_ext)
        begin
            nxt.rem  = DIV_W'(trial - dvs_ext);
            nxt.work = {cur.work[QW-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = trial[DIV_W-1:0];
            nxt.work = {cur.work[QW-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

@@ hdl/rhc_stream_if.sv @@
// Handshake channels for pixel requests and HSV results.
interface rhc_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [rhc_pkg::COMP_W-1:0]  green_in;
    logic [rhc_pkg::COMP_W-1:0]  red_in;
    logic [rhc_pkg::COMP_W-1:0]  blue_in;

    modport source (output valid, output green_in, output red_in, output blue_in,
                    input ready);
    modport sink   (input valid, input green_in, input red_in, input blue_in,
                    output ready);
endinterface

interface rhc_hsv_if;
    logic                        valid;
    logic                        ready;
    logic [rhc_pkg::HUE_W-1:0]   hue_out;
    logic [rhc_pkg::SAT_W-1:0]   saturation_out;
    logic [rhc_pkg::VAL_W-1:0]   value_out;

    modport source (output valid, output hue_out, output saturation_out,
                    output value_out, input ready);
    modport sink   (input valid, input hue_out, input saturation_out,
                    input value_out, output ready);
endinterface

@@ hdl/rgb_to_hsv_converter_unit.sv @@
// Top level of the RGB to HSV converter: front stage and a chain of divider cells.
//
// Usage:
//   pixel carries one request of three 8-bit components (green, red, blue);
//   hsv returns hue in 1/64 degree, saturation in 1/65536 and value (the max).
//   A request is taken when valid and ready are both high; one result
//   comes back for every request, in order.
// Pipeline: one front stage for max, min and sector, then one cell per
//   quotient bit of the rounded divisions, each cell working on both
//   hue and saturation; every cell holds a different pixel.
// Throughput: one pixel per clock whenever the chain advances (see Stall).
// Reset: clears every valid bit in the chain; nothing else needs clearing.
// Stall: when hsv.ready is low with a result waiting, the whole chain holds
//   and pixel.ready drops; an empty output slot lets the chain advance and
//   fill bubbles even while the receiver is stalled.
module rgb_to_hsv_converter_unit (
    input  logic     clk,
    input  logic     rst_n,
    rhc_pixel_if.sink  pixel,
    rhc_hsv_if.source  hsv
);

    rhc_pkg::stage_t  chain [0:rhc_pkg::QW];
    logic             advance;

    assign advance     = !chain[rhc_pkg::QW].valid || hsv.ready;
    assign pixel.ready = advance;

    rhc_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .valid   (pixel.valid),
        .green   (pixel.green_in),
        .red     (pixel.red_in),
        .blue    (pixel.blue_in),
        .stage   (chain[0])
    );

    for (genvar i = 0; i < rhc_pkg::QW; i++)
    begin : g_cell
        rhc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .prev    (chain[i]),
            .stage   (chain[i+1])
        );
    end

    assign hsv.valid          = chain[rhc_pkg::QW].valid;
    assign hsv.hue_out        = chain[rhc_pkg::QW].hue.work[rhc_pkg::HUE_W-1:0];
    assign hsv.saturation_out = chain[rhc_pkg::QW].sat.work[rhc_pkg::SAT_W-1:0];
    assign hsv.value_out      = chain[rhc_pkg::QW].value;

endmodule

@@ hdl/rhc_prep.sv @@
// Front stage: max, min, hue sector and the two rounded-division operands.
module rhc_prep (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        valid,
    input  logic [rhc_pkg::COMP_W-1:0]  green,
    input  logic [rhc_pkg::COMP_W-1:0]  red,
    input  logic [rhc_pkg::COMP_W-1:0]  blue,
    output rhc_pkg::stage_t             stage
);

    logic [rhc_pkg::COMP_W-1:0]    mx;
    logic [rhc_pkg::COMP_W-1:0]    mn;
    logic [rhc_pkg::COMP_W-1:0]    delta;
    logic [rhc_pkg::COMP_W-1:0]    x_comp;
    logic [rhc_pkg::COMP_W-1:0]    y_comp;
    logic [rhc_pkg::OFF_W-1:0]     offset;
    logic [rhc_pkg::SCALED_W-1:0]  scaled;
    logic [rhc_pkg::NUM_W-1:0]     hue_num;
    logic [rhc_pkg::NUM_W-1:0]     sat_num;
    logic [rhc_pkg::DIV_W-1:0]     hue_dvs;
    logic [rhc_pkg::DIV_W-1:0]     sat_dvs;
    rhc_pkg::stage_t               stage_next;
    logic                          valid_reg;
    rhc_pkg::stage_t               data_reg;

    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        delta = mx - mn;

        // Ties for the maximum go to red, then green.
        if (mx == red)
        begin
            x_comp = green;
            y_comp = blue;
            offset = (green >= blue) ? rhc_pkg::OFFSET_RED : rhc_pkg::OFFSET_RED_WRAP;
        end
        else if (mx == green)
        begin
            x_comp = blue;
            y_comp = red;
            offset = rhc_pkg::OFFSET_GREEN;
        end
        else
        begin
            x_comp = red;
            y_comp = green;
            offset = rhc_pkg::OFFSET_BLUE;
        end

        // Wraps modulo 2^SCALED_W on the way, but the final sum is never negative.
        scaled = rhc_pkg::SCALED_W'(rhc_pkg::SCALED_W'(offset) * rhc_pkg::SCALED_W'(delta))
               + rhc_pkg::SCALED_W'(rhc_pkg::SIXTY * rhc_pkg::SCALED_W'(x_comp))
               - rhc_pkg::SCALED_W'(rhc_pkg::SIXTY * rhc_pkg::SCALED_W'(y_comp));

        // Round to nearest, ties up: (2N + D) / (2D).
        if (delta == '0)
        begin
            hue_num = '0;
            hue_dvs = rhc_pkg::DIV_W'(1);
        end
        else
        begin
            hue_num = (rhc_pkg::NUM_W'(scaled) << (rhc_pkg::HUE_FRAC_BITS + 1))
                    + rhc_pkg::NUM_W'(delta);
            hue_dvs = {delta, 1'b0};
        end

        if (mx == '0)
        begin
            sat_num = '0;
            sat_dvs = rhc_pkg::DIV_W'(1);
        end
        else
        begin
            sat_num = (rhc_pkg::NUM_W'(delta) << (rhc_pkg::SAT_FRAC_BITS + 1))
                    + rhc_pkg::NUM_W'(mx);
            sat_dvs = {mx, 1'b0};
        end

        // The top part is already below the divisor, since the quotient fits QW bits.
        stage_next.valid    = valid;
        stage_next.hue.rem  = hue_num[rhc_pkg::NUM_W-1:rhc_pkg::QW];
        stage_next.hue.work = hue_num[rhc_pkg::QW-1:0];
        stage_next.hue.dvs  = hue_dvs;
        stage_next.sat.rem  = sat_num[rhc_pkg::NUM_W-1:rhc_pkg::QW];
        stage_next.sat.work = sat_num[rhc_pkg::QW-1:0];
        stage_next.sat.dvs  = sat_dvs;
        stage_next.value    = mx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= stage_next;
        end
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

@@ hdl/rhc_cell.sv @@
// One divider cell: resolves one quotient bit of hue and of saturation.
module rhc_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  rhc_pkg::stage_t  prev,
    output rhc_pkg::stage_t  stage
);

    rhc_pkg::stage_t  stage_next;
    logic             valid_reg;
    rhc_pkg::stage_t  data_reg;

    always_comb
    begin
        stage_next       = prev;
        stage_next.hue   = rhc_pkg::div_step(prev.hue);
        stage_next.sat   = rhc_pkg::div_step(prev.sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= stage_next;
        end
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

@@ hdl/rhc_checker.sv @@
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rhc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [rhc_pkg::HUE_W-1:0]   hue_out,
    input  logic [rhc_pkg::SAT_W-1:0]   saturation_out,
    input  logic [rhc_pkg::VAL_W-1:0]   value_out
);

    localparam logic [rhc_pkg::SAT_W:0] SAT_ONE = (rhc_pkg::SAT_W+1)'(1) << rhc_pkg::SAT_FRAC_BITS;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_out))
        else $error("result dropped or changed while stalled");

    a_in_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("requests refused with an empty output slot");

    a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_out == '0 |-> saturation_out == '0 && hue_out == '0)
        else $error("black pixel with nonzero hue or saturation");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, saturation_out} <= SAT_ONE)
        else $error("saturation above one");

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (pixel.ready),
    .out_valid      (hsv.valid),
    .out_ready      (hsv.ready),
    .hue_out        (hsv.hue_out),
    .saturation_out (hsv.saturation_out),
    .value_out      (hsv.value_out)
);
